// File: design/necird_pkg.sv
// shared types and constants for the nec infrared frame decoder
// no dependencies; imported by every module of the decoder

package necird_pkg;

  localparam int FRAME_BITS = 32;
  localparam int BYTE_W     = 8;
  localparam int IVL_W      = 18;
  localparam int CNT_W      = $clog2(FRAME_BITS + 2);
  localparam int BIT_IDX_W  = $clog2(FRAME_BITS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = IVL_W;

  localparam logic [CNT_W-1:0] EDGE_LIMIT = CNT_W'(FRAME_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_EDGE  = CNT_W'(FRAME_BITS);

  localparam logic [IVL_W-1:0] ONE_MIN_RESET = IVL_W'(2000);
  localparam logic [IVL_W-1:0] ONE_MAX_RESET = IVL_W'(2400);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_MODE = 2'd2;

  // result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef enum logic [1:0] {
    ACT_EDGE    = 2'd0,
    ACT_TIMEOUT = 2'd1,
    ACT_READ    = 2'd2
  } action_t;

  typedef struct packed {
    logic              report_kind;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] address;
    logic              valid_res;
  } res_t;

endpackage

// File: design/necird_in_stage.sv
// input register of the nec decoder: holds one item until the core takes it
// depends on necird_pkg

module necird_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [necird_pkg::IVL_W-1:0] in_interval,
  input  logic                      take,
  output logic                      item_valid_r,
  output necird_pkg::action_t       action_r,
  output logic [necird_pkg::IVL_W-1:0] interval_r
);
  import necird_pkg::*;

  logic item_valid_nxt;
  logic load;

  // free slot, or the held item leaves this cycle
  assign in_ready = !item_valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (load) begin
      item_valid_nxt = 1'b1;
    end else if (take) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      action_r   <= action_t'(in_action);
      interval_r <= in_interval;
    end
  end

endmodule

// File: design/necird_core.sv
// frame state, configuration registers and decode logic of the nec decoder
// depends on necird_pkg

module necird_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [necird_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [necird_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                          fire,
  input  necird_pkg::action_t           action,
  input  logic [necird_pkg::IVL_W-1:0]  interval,
  output logic                          res_vld,
  output necird_pkg::res_t              res
);
  import necird_pkg::*;

  logic [IVL_W-1:0]      one_min_r, one_min_nxt;
  logic [IVL_W-1:0]      one_max_r, one_max_nxt;
  logic                  deliver_mode_r, deliver_mode_nxt;
  logic                  in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]      edge_count_r, edge_count_nxt;
  logic [FRAME_BITS-1:0] frame_bits_r, frame_bits_nxt;
  logic [BYTE_W-1:0]     address_r, address_nxt;
  logic [BYTE_W-1:0]     command_r, command_nxt;
  logic                  pending_r, pending_nxt;

  logic [BIT_IDX_W-1:0]  bit_idx;
  logic                  is_one;
  logic [BYTE_W-1:0]     addr_byte, addr_inv, cmd_byte, cmd_inv;
  logic                  addr_ok, cmd_ok;

  assign bit_idx   = BIT_IDX_W'(edge_count_r - CNT_W'(1));
  assign is_one    = (interval >= one_min_r) && (interval <= one_max_r);
  assign addr_byte = frame_bits_r[BYTE_W-1:0];
  assign addr_inv  = frame_bits_r[2*BYTE_W-1:BYTE_W];
  assign cmd_byte  = frame_bits_r[3*BYTE_W-1:2*BYTE_W];
  assign cmd_inv   = frame_bits_r[4*BYTE_W-1:3*BYTE_W];
  assign addr_ok   = (addr_byte == ~addr_inv);
  assign cmd_ok    = (cmd_byte == ~cmd_inv);

  always_comb begin
    one_min_nxt      = one_min_r;
    one_max_nxt      = one_max_r;
    deliver_mode_nxt = deliver_mode_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ONE_MIN:      one_min_nxt = cfg_wdata[IVL_W-1:0];
        CFG_ONE_MAX:      one_max_nxt = cfg_wdata[IVL_W-1:0];
        CFG_DELIVER_MODE: deliver_mode_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame_nxt   = in_frame_r;
    edge_count_nxt = edge_count_r;
    frame_bits_nxt = frame_bits_r;
    address_nxt    = address_r;
    command_nxt    = command_r;
    pending_nxt    = pending_r;
    res_vld        = 1'b0;
    res            = '{report_kind: KIND_READ, command: command_r,
                       address: address_r, valid_res: pending_r};
    if (fire) begin
      unique case (action)
        ACT_EDGE: begin
          if (!in_frame_r) begin
            in_frame_nxt = 1'b1;
          end else begin
            // leader interval (count 0) carries no bit
            if ((edge_count_r != '0) && (edge_count_r <= LAST_EDGE)) begin
              frame_bits_nxt[bit_idx] = is_one;
            end
            if (edge_count_r < EDGE_LIMIT) begin
              edge_count_nxt = edge_count_r + CNT_W'(1);
            end
          end
        end
        ACT_TIMEOUT: begin
          if (in_frame_r) begin
            address_nxt = addr_byte;
            if (addr_ok) begin
              command_nxt = cmd_byte;
              if (cmd_ok) begin
                if (deliver_mode_r) begin
                  res_vld     = 1'b1;
                  res         = '{report_kind: KIND_DELIVER, command: cmd_byte,
                                  address: addr_byte, valid_res: 1'b1};
                  pending_nxt = 1'b0;
                end else begin
                  pending_nxt = 1'b1;
                end
              end
            end
            in_frame_nxt   = 1'b0;
            edge_count_nxt = '0;
          end
        end
        ACT_READ: begin
          res_vld     = 1'b1;
          pending_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_min_r      <= ONE_MIN_RESET;
      one_max_r      <= ONE_MAX_RESET;
      deliver_mode_r <= 1'b0;
      in_frame_r     <= 1'b0;
      edge_count_r   <= '0;
      frame_bits_r   <= '0;
      address_r      <= '0;
      command_r      <= '0;
      pending_r      <= 1'b0;
    end else begin
      one_min_r      <= one_min_nxt;
      one_max_r      <= one_max_nxt;
      deliver_mode_r <= deliver_mode_nxt;
      in_frame_r     <= in_frame_nxt;
      edge_count_r   <= edge_count_nxt;
      frame_bits_r   <= frame_bits_nxt;
      address_r      <= address_nxt;
      command_r      <= command_nxt;
      pending_r      <= pending_nxt;
    end
  end

endmodule

// File: design/necird_out_reg.sv
// result register of the nec decoder, held until the consumer takes it
// depends on necird_pkg

module necird_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  necird_pkg::res_t res_in,
  input  logic             out_ready,
  output logic             slot_free,
  output logic             out_valid_r,
  output necird_pkg::res_t res_r
);
  import necird_pkg::*;

  logic out_valid_nxt;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

// File: design/nec_ir_frame_decoder.sv
// top level of the nec infrared frame decoder
// depends on necird_pkg, necird_in_stage, necird_core, necird_out_reg
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_action, in_interval
//   out_     output     out_valid / out_ready out_report_kind, out_command,
//                                             out_address, out_valid_res
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// an accepted item is decoded straight out of the input register and its result
// is registered in the output register, which drives out_valid
// one item per cycle is sustained while out_ready stays high
// a result held in the output register stalls decoding; the input register
// still takes one more item meanwhile
// rst_n is synchronous and clears frame state, pending flag and config to defaults

module nec_ir_frame_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [necird_pkg::IVL_W-1:0]  in_interval,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_report_kind,
  output logic [necird_pkg::BYTE_W-1:0] out_command,
  output logic [necird_pkg::BYTE_W-1:0] out_address,
  output logic                          out_valid_res,
  input  logic                          cfg_we,
  input  logic [necird_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [necird_pkg::CFG_W-1:0]  cfg_wdata
);
  import necird_pkg::*;

  logic             item_valid_r;
  action_t          action_r;
  logic [IVL_W-1:0] interval_r;
  logic             slot_free;
  logic             fire;
  logic             res_vld;
  res_t             res;
  res_t             res_r;

  assign fire = item_valid_r && slot_free;

  necird_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_interval  (in_interval),
    .take         (fire),
    .item_valid_r (item_valid_r),
    .action_r     (action_r),
    .interval_r   (interval_r)
  );

  necird_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .action    (action_r),
    .interval  (interval_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  necird_out_reg u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (res_vld),
    .res_in      (res),
    .out_ready   (out_ready),
    .slot_free   (slot_free),
    .out_valid_r (out_valid),
    .res_r       (res_r)
  );

  assign out_report_kind = res_r.report_kind;
  assign out_command     = res_r.command;
  assign out_address     = res_r.address;
  assign out_valid_res   = res_r.valid_res;

endmodule

// File: design/necird_chk.sv
// port-level checks for the nec infrared frame decoder, bound to the top level
// depends on necird_pkg and nec_ir_frame_decoder

module necird_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_report_kind,
  input logic [necird_pkg::BYTE_W-1:0] out_command,
  input logic [necird_pkg::BYTE_W-1:0] out_address,
  input logic                          out_valid_res
);
  import necird_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_report_kind)
      && $stable(out_command) && $stable(out_address) && $stable(out_valid_res))
    else $error("result changed while stalled");

  // a delivery is only made for a checked frame
  a_deliver_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_report_kind == KIND_DELIVER) |-> out_valid_res)
    else $error("delivery without valid flag");

  // a read clears pending, so back-to-back read replies cannot both be fresh
  a_pending_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && (out_report_kind == KIND_READ) && out_valid_res)
      ##1 (out_valid && out_ready)
      |-> !((out_report_kind == KIND_READ) && out_valid_res))
    else $error("pending flag reported twice");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nec_ir_frame_decoder necird_chk u_necird_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_report_kind (out_report_kind),
  .out_command     (out_command),
  .out_address     (out_address),
  .out_valid_res   (out_valid_res)
);

// File: test/tb_nec_ir_frame_decoder.sv
// self-checking testbench for nec_ir_frame_decoder: directed and random edge, timeout and
// read items under several register settings, results checked against a behavioural model
// depends on necird_pkg and the decoder rtl; reads no files

module tb_nec_ir_frame_decoder;
  import necird_pkg::*;

  localparam logic [1:0]       ACT_UNUSED    = 2'd3;
  localparam logic [IVL_W-1:0] IVL_MAX       = '1;
  localparam int               HOLD_CYCLES   = 300;
  localparam int               SETTLE_CYCLES = 8;
  localparam int               CYCLE_LIMIT   = 400000;

  localparam int FRAME_GOOD    = 0;
  localparam int FRAME_FLIPPED = 1;
  localparam int FRAME_SHORT   = 2;
  localparam int FRAME_LONG    = 3;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKED} rx_mode_t;

  // model of the decoder plus the queue of results still owed by it
  class nec_decode_board;
    logic [IVL_W-1:0]  one_min;
    logic [IVL_W-1:0]  one_max;
    logic              deliver_mode;
    logic              in_frame;
    logic [CNT_W-1:0]  edge_count;
    logic [31:0]       frame_bits;
    logic [BYTE_W-1:0] address_q;
    logic [BYTE_W-1:0] command_q;
    logic              pending;
    res_t              expected_reports[$];
    int                failures;

    function new();
      one_min      = ONE_MIN_RESET;
      one_max      = ONE_MAX_RESET;
      deliver_mode = 1'b0;
      in_frame     = 1'b0;
      edge_count   = '0;
      frame_bits   = '0;
      address_q    = '0;
      command_q    = '0;
      pending      = 1'b0;
      failures     = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      case (idx)
        CFG_ONE_MIN:      one_min = val;
        CFG_ONE_MAX:      one_max = val;
        CFG_DELIVER_MODE: deliver_mode = val[0];
        default: ;
      endcase
    endfunction

    function void note_item(input logic [1:0] act, input logic [IVL_W-1:0] ivl);
      res_t r;
      case (act)
        ACT_EDGE: begin
          if (!in_frame) begin
            in_frame = 1'b1;
          end else begin
            // the leader interval (count 0) carries no bit
            if (edge_count >= 1 && edge_count <= LAST_EDGE)
              frame_bits[edge_count - 1] = (ivl >= one_min) && (ivl <= one_max);
            if (edge_count < EDGE_LIMIT)
              edge_count = edge_count + 1'b1;
          end
        end
        ACT_TIMEOUT: begin
          if (in_frame) begin
            address_q = frame_bits[7:0];
            if (address_q == ~frame_bits[15:8]) begin
              command_q = frame_bits[23:16];
              if (command_q == ~frame_bits[31:24]) begin
                if (deliver_mode) begin
                  r.report_kind = KIND_DELIVER;
                  r.command     = command_q;
                  r.address     = address_q;
                  r.valid_res   = 1'b1;
                  expected_reports.push_back(r);
                  pending = 1'b0;
                end else begin
                  pending = 1'b1;
                end
              end
            end
            in_frame   = 1'b0;
            edge_count = '0;
          end
        end
        ACT_READ: begin
          r.report_kind = KIND_READ;
          r.command     = command_q;
          r.address     = address_q;
          r.valid_res   = pending;
          expected_reports.push_back(r);
          pending = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void note_failure(input string msg);
      failures++;
      if (failures <= 10)
        $display("mismatch: %s", msg);
    endfunction

    function void check_report(input res_t got);
      res_t want;
      if (expected_reports.size() == 0) begin
        note_failure($sformatf("unexpected result kind %0d cmd %02h addr %02h valid %0d",
                               got.report_kind, got.command, got.address, got.valid_res));
        return;
      end
      want = expected_reports.pop_front();
      if (got.report_kind !== want.report_kind || got.command !== want.command ||
          got.address !== want.address || got.valid_res !== want.valid_res)
        note_failure($sformatf(
          {"expected kind %0d cmd %02h addr %02h valid %0d, ",
           "got kind %0d cmd %02h addr %02h valid %0d"},
          want.report_kind, want.command, want.address, want.valid_res,
          got.report_kind, got.command, got.address, got.valid_res));
    endfunction
  endclass

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [1:0]        in_action   = ACT_EDGE;
  logic [IVL_W-1:0]  in_interval = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic              out_report_kind;
  logic [BYTE_W-1:0] out_command;
  logic [BYTE_W-1:0] out_address;
  logic              out_valid_res;
  logic              cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ONE_MIN;
  logic [CFG_W-1:0]  cfg_wdata   = '0;

  nec_decode_board board = new();

  int work_items    = 0;
  int burst_left    = 10;
  bit steady_burst  = 1'b0;
  int hold_requests = 0;
  int holds_done    = 0;
  int cycle_count   = 0;

  nec_ir_frame_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_interval     (in_interval),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_report_kind (out_report_kind),
    .out_command     (out_command),
    .out_address     (out_address),
    .out_valid_res   (out_valid_res),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_report({out_report_kind, out_command, out_address, out_valid_res});
  end

  // result side: changing stall patterns, plus long hold-offs on request
  initial begin : receiver
    int       seg_left;
    rx_mode_t mode;
    seg_left = 0;
    mode     = RX_OPEN;
    forever begin
      @(posedge clk);
      if (holds_done < hold_requests) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(3, 0));
          seg_left = $urandom_range(60, 5);
        end
        seg_left--;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(1, 0));
          RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
          default:   out_ready <= ($urandom_range(9, 0) == 0);
        endcase
      end
    end
  end

  task automatic push_item(input logic [1:0] act, input logic [IVL_W-1:0] ivl);
    in_valid    <= 1'b1;
    in_action   <= act;
    in_interval <= ivl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(act, ivl);
    if (act != ACT_UNUSED)
      work_items++;
    if (!steady_burst) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk);
        burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 60)
                                                 : $urandom_range(30, 1);
      end
    end
  endtask

  // interval that decodes to the wanted bit under the bounds in force
  function automatic logic [IVL_W-1:0] pick_interval(input logic one);
    if (one && board.one_min <= board.one_max)
      return IVL_W'($urandom_range(board.one_max, board.one_min));
    if (board.one_min != 0 && (board.one_max == IVL_MAX || $urandom_range(1, 0) == 1))
      return IVL_W'($urandom_range(board.one_min - 1, 0));
    if (board.one_max != IVL_MAX)
      return IVL_W'($urandom_range(IVL_MAX, board.one_max + 1));
    return IVL_W'($urandom);
  endfunction

  task automatic send_frame(input int shape);
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] cmd;
    logic [31:0]       word;
    int                nbits;
    addr  = BYTE_W'($urandom);
    cmd   = BYTE_W'($urandom);
    word  = {~cmd, cmd, ~addr, addr};
    nbits = FRAME_BITS;
    case (shape)
      FRAME_FLIPPED: word[$urandom_range(31, 0)] ^= 1'b1;
      FRAME_SHORT:   nbits = $urandom_range(31, 0);
      FRAME_LONG:    nbits = $urandom_range(40, 33);
      default: ;
    endcase
    push_item(ACT_EDGE, IVL_W'($urandom));
    push_item(ACT_EDGE, IVL_W'($urandom_range(14000, 13000)));
    for (int i = 0; i < nbits; i++)
      push_item(ACT_EDGE, pick_interval(i < FRAME_BITS ? word[i]
                                                       : 1'($urandom_range(1, 0))));
    push_item(ACT_TIMEOUT, IVL_W'($urandom));
    if (!board.deliver_mode && $urandom_range(1, 0) == 1)
      push_item(ACT_READ, IVL_W'($urandom));
  endtask

  task automatic decode_traffic(input int target);
    int pick;
    while (work_items < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 55)
        send_frame(FRAME_GOOD);
      else if (pick < 65)
        send_frame($urandom_range(FRAME_LONG, FRAME_FLIPPED));
      else if (pick < 80)
        push_item(ACT_READ, IVL_W'($urandom));
      else if (pick < 87)
        push_item(ACT_TIMEOUT, IVL_W'($urandom));
      else if (pick < 91)
        push_item(ACT_UNUSED, IVL_W'($urandom));
      else
        push_item(ACT_EDGE, IVL_W'($urandom));
    end
  endtask

  // an item with no result may still be inside the block, hence the extra cycles
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (board.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [IVL_W-1:0] lo, input logic [IVL_W-1:0] hi,
                               input logic mode);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ONE_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    board.set_reg(CFG_ONE_MIN, lo);
    cfg_index <= CFG_ONE_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    board.set_reg(CFG_ONE_MAX, hi);
    cfg_index <= CFG_DELIVER_MODE;
    cfg_wdata <= CFG_W'(mode);
    @(posedge clk);
    board.set_reg(CFG_DELIVER_MODE, CFG_W'(mode));
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [IVL_W-1:0] lo;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // read with nothing pending, timeout while idle, unused code
    push_item(ACT_READ, '0);
    push_item(ACT_TIMEOUT, IVL_MAX);
    push_item(ACT_UNUSED, IVL_MAX);
    // short frame around the bounds of a one; address check fails
    push_item(ACT_EDGE, '0);
    push_item(ACT_EDGE, IVL_MAX);
    push_item(ACT_EDGE, '0);
    push_item(ACT_EDGE, ONE_MIN_RESET);
    push_item(ACT_EDGE, ONE_MAX_RESET);
    push_item(ACT_EDGE, ONE_MAX_RESET + 1'b1);
    push_item(ACT_EDGE, ONE_MIN_RESET - 1'b1);
    push_item(ACT_EDGE, IVL_MAX);
    push_item(ACT_TIMEOUT, '0);
    push_item(ACT_READ, IVL_MAX);

    decode_traffic(260);
    wait_until_idle();

    apply_setting(ONE_MIN_RESET, ONE_MAX_RESET, 1'b1);
    // long receiver hold-off while reads keep coming, so the input side backs up
    hold_requests++;
    steady_burst = 1'b1;
    repeat (30) push_item(ACT_READ, IVL_W'($urandom));
    steady_burst = 1'b0;
    decode_traffic(560);
    wait_until_idle();

    // bounds crossed: nothing decodes to a one
    apply_setting(IVL_MAX, '0, 1'b0);
    decode_traffic(720);
    wait_until_idle();

    apply_setting('0, IVL_MAX, 1'b1);
    decode_traffic(880);
    wait_until_idle();

    apply_setting('0, '0, 1'b1);
    decode_traffic(1080);
    wait_until_idle();

    apply_setting(IVL_MAX, IVL_MAX, 1'b0);
    decode_traffic(1280);
    wait_until_idle();

    repeat (2) begin
      lo = IVL_W'($urandom_range(200000, 1));
      apply_setting(lo, lo + IVL_W'($urandom_range(3000, 0)), 1'($urandom_range(1, 0)));
      decode_traffic(work_items + 190);
      wait_until_idle();
    end

    repeat (20) @(posedge clk);
    if (board.expected_reports.size() != 0)
      board.note_failure($sformatf("%0d results never arrived",
                                   board.expected_reports.size()));
    if (board.failures == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
